FILE: hdl/srf_pkg.sv
// shared constants and helper functions of the signed radix formatter
package srf_pkg;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned ALPHA_W     = 64;
  localparam int unsigned ALPHA_CHARS = 16;
  localparam int unsigned DIGIT_SLOTS = 32;
  localparam int unsigned SLOT_W      = $clog2(DIGIT_SLOTS);
  localparam int unsigned COUNT_W     = SLOT_W + 1;
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned STEPS       = NUM_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W  = $clog2(STEPS);
  localparam int unsigned MAX_RADIX_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ALPHA_W;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  // alphabet character k, low register holds characters 0 to 7
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] low,
                                                   input logic [ALPHA_W-1:0] high,
                                                   input logic [DIGIT_W-1:0] k);
    logic [2*ALPHA_W-1:0] both;
    both = {high, low};
    return both[k*CHAR_W +: CHAR_W];
  endfunction

  // characters in use must be printable, not a sign and all distinct
  function automatic logic alpha_chars_ok(input logic [ALPHA_W-1:0] low,
                                          input logic [ALPHA_W-1:0] high,
                                          input logic [RADIX_W-1:0] radix);
    logic              ok;
    logic [CHAR_W-1:0] ca;
    logic [CHAR_W-1:0] cb;
    ok = 1'b1;
    for (int a = 0; a < ALPHA_CHARS; a++) begin
      ca = alpha_char(low, high, DIGIT_W'(a));
      if (RADIX_W'(a) < radix) begin
        if (ca < CHAR_LOW || ca > CHAR_HIGH || ca == CHAR_PLUS || ca == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int b = 0; b < a; b++) begin
          cb = alpha_char(low, high, DIGIT_W'(b));
          if (cb == ca) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

FILE: hdl/signed_radix_formatter.sv
// top level of the signed radix formatter: config registers, sequencer, digit stack
//
// Formats one signed 32-bit number per input word as text in the radix set by
// radix_size, using the configured alphabet (alphabet_low holds digit chars 0-7,
// alphabet_high chars 8-15, lowest byte first). Each output word is one char,
// most significant first, a '-' leading for negatives; last_o marks the final
// char and zero comes out as alphabet char 0. If the alphabet is invalid
// (radix below 2 or above MAX_RADIX, a char outside 32..126, a '+' or '-', or
// a repeated char) a single word with error_o and last_o set and char 0 is
// sent instead. One number is worked at a time: in_stall_o is low only while
// the sequencer is idle. Steps: the alphabet check, then the digits in the
// shared divide unit (eight quotient bits a cycle, so a 32-bit magnitude takes
// four passes per digit), each remainder pushed on the digit stack, then a '-'
// for negatives, then per digit a read of the digit stack and a load of the
// output register; the sign and the loads wait while the output side stalls.
// Config writes are taken in any cycle but must only happen while no number
// is in work.
module signed_radix_formatter #(
  parameter int unsigned MAX_RADIX = srf_pkg::MAX_RADIX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [srf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [srf_pkg::NUM_W-1:0] number_i,
  // output words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [srf_pkg::CHAR_W-1:0]      character_o,
  output logic                            last_o,
  output logic                            error_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_e;

  // config registers
  logic [srf_pkg::ALPHA_W-1:0] alpha_low_q, alpha_high_q;
  logic [srf_pkg::RADIX_W-1:0] radix_q;

  // sequencer state
  state_e                          state_q, state_d;
  logic                            neg_q, neg_d;
  logic [srf_pkg::NUM_W-1:0]       mag_q, mag_d;
  logic [srf_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic [srf_pkg::STEP_CNT_W-1:0]  step_q, step_d;
  logic [srf_pkg::COUNT_W-1:0]     count_q, count_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [srf_pkg::CHAR_W-1:0]      char_q, char_d;
  logic                            last_q, last_d;
  logic                            err_q, err_d;

  // digit stack, no reset: every slot is written before it is read
  logic [srf_pkg::DIGIT_W-1:0]     stack_mem [srf_pkg::DIGIT_SLOTS];
  logic [srf_pkg::DIGIT_W-1:0]     rd_q;
  logic                            stack_we, stack_re;
  logic [srf_pkg::SLOT_W-1:0]      stack_waddr, stack_raddr;

  // divide unit hookup
  logic [srf_pkg::STEP_BITS-1:0]   quot_byte;
  logic [srf_pkg::DIGIT_W-1:0]     rem_next;
  logic [srf_pkg::NUM_W-1:0]       quot_full;

  logic                            alpha_ok;
  logic                            out_free;
  logic                            in_accept;
  logic [srf_pkg::COUNT_W-1:0]     count_dec;

  srf_div_step u_div_step (
    .rem_i      (rem_q),
    .dividend_i (mag_q[srf_pkg::NUM_W-1 -: srf_pkg::STEP_BITS]),
    .radix_i    (radix_q),
    .quot_o     (quot_byte),
    .rem_o      (rem_next)
  );

  // dividend shifts left a byte per pass, quotient bytes fill in from the bottom
  assign quot_full = {mag_q[srf_pkg::NUM_W-srf_pkg::STEP_BITS-1:0], quot_byte};

  assign alpha_ok = (radix_q >= srf_pkg::MIN_RADIX) &&
                    (radix_q <= srf_pkg::RADIX_W'(MAX_RADIX)) &&
                    srf_pkg::alpha_chars_ok(alpha_low_q, alpha_high_q, radix_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign count_dec  = count_q - srf_pkg::COUNT_W'(1);

  assign stack_waddr = count_q[srf_pkg::SLOT_W-1:0];
  assign stack_raddr = count_dec[srf_pkg::SLOT_W-1:0];

  // config writes, out-of-range index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
      radix_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        srf_pkg::REG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i;
        srf_pkg::REG_ALPHA_HIGH: alpha_high_q <= cfg_data_i;
        srf_pkg::REG_RADIX_SIZE: radix_q      <= cfg_data_i[srf_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    step_d      = step_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;
    stack_we    = 1'b0;
    stack_re    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // unsigned magnitude so the most negative value needs no extra bit
          neg_d   = number_i[srf_pkg::NUM_W-1];
          mag_d   = number_i[srf_pkg::NUM_W-1] ? (srf_pkg::NUM_W'(0) - $unsigned(number_i))
                                               : $unsigned(number_i);
          rem_d   = '0;
          step_d  = '0;
          count_d = '0;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (alpha_ok) begin
          state_d = ST_DIVIDE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = srf_pkg::CHAR_NONE;
          last_d      = 1'b1;
          err_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_DIVIDE: begin
        mag_d  = quot_full;
        rem_d  = rem_next;
        step_d = step_q + srf_pkg::STEP_CNT_W'(1);
        if (step_q == srf_pkg::STEP_CNT_W'(srf_pkg::STEPS - 1)) begin
          // digit done: push remainder, start next digit from zero
          stack_we = 1'b1;
          count_d  = count_q + srf_pkg::COUNT_W'(1);
          rem_d    = '0;
          if (quot_full == '0 ||
              count_q == srf_pkg::COUNT_W'(srf_pkg::DIGIT_SLOTS - 1)) begin
            state_d = neg_q ? ST_SIGN : ST_FETCH;
          end
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = srf_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          err_d       = 1'b0;
          state_d     = ST_FETCH;
        end
      end

      ST_FETCH: begin
        // stack read is registered, the char is formed from it in ST_EMIT
        stack_re = 1'b1;
        count_d  = count_dec;
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = srf_pkg::alpha_char(alpha_low_q, alpha_high_q, rd_q);
          last_d      = (count_q == '0);
          err_d       = 1'b0;
          state_d     = (count_q == '0) ? ST_IDLE : ST_FETCH;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      err_q       <= err_d;
    end
  end

  // digit stack write and registered read
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= rem_next;
    end
    if (stack_re) begin
      rd_q <= stack_mem[stack_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

FILE: hdl/srf_div_step.sv
// one shared divide step: eight restoring quotient bits per cycle
module srf_div_step (
  input  logic [srf_pkg::DIGIT_W-1:0]   rem_i,
  input  logic [srf_pkg::STEP_BITS-1:0] dividend_i,
  input  logic [srf_pkg::RADIX_W-1:0]   radix_i,
  output logic [srf_pkg::STEP_BITS-1:0] quot_o,
  output logic [srf_pkg::DIGIT_W-1:0]   rem_o
);

  logic [srf_pkg::RADIX_W-1:0] part;

  // remainder stays below radix, so twice it plus one fits in RADIX_W bits
  always_comb begin
    part   = {1'b0, rem_i};
    quot_o = '0;
    for (int i = srf_pkg::STEP_BITS - 1; i >= 0; i--) begin
      part = {part[srf_pkg::RADIX_W-2:0], dividend_i[i]};
      if (part >= radix_i) begin
        part      = part - radix_i;
        quot_o[i] = 1'b1;
      end
    end
    rem_o = part[srf_pkg::DIGIT_W-1:0];
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the signed radix formatter: directed table, then random alphabets
module tb_top;

  // watchdog limit, a wide margin over the slowest correct run
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned     ITEMS_PER_PHASE = 28;
  localparam int unsigned     RANDOM_PHASES   = 12;
  // register index past the last register, a write there must change nothing
  localparam logic [srf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one output word as it should come out of the block
  typedef struct packed {
    logic [srf_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       err;
  } char_word_t;

  // directed table: alphabet setups, numbers with typed-in text, numbers left to the predictor
  typedef enum logic [1:0] {ROW_SETUP, ROW_TYPED, ROW_MODEL} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [2*srf_pkg::ALPHA_W-1:0]   alpha;
    logic [srf_pkg::RADIX_W-1:0]     radix;
    logic [srf_pkg::NUM_W-1:0]       num;
    string                           text;   // empty text on a typed row means the error word
  } step_row_t;

  // dut signals, every input known from time zero
  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [srf_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [srf_pkg::CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic signed [srf_pkg::NUM_W-1:0] number_i    = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [srf_pkg::CHAR_W-1:0]       character_o;
  logic                             last_o;
  logic                             error_o;

  // shadow copy of the config registers, mirrors every write
  logic [srf_pkg::ALPHA_W-1:0] alpha_lo_q  = '0;
  logic [srf_pkg::ALPHA_W-1:0] alpha_hi_q  = '0;
  logic [srf_pkg::RADIX_W-1:0] radix_q     = '0;

  char_word_t pending_chars[$];
  step_row_t  dir_rows[$];

  // idling controls for the two sides
  bit sender_idle_en = 1'b1;
  bit sink_idle_en   = 1'b1;
  int stall_hold     = 0;

  int unsigned     mismatches    = 0;
  int unsigned     words_checked = 0;
  int unsigned     numbers_sent  = 0;
  int unsigned     setups_done   = 0;
  int unsigned     bad_setups    = 0;
  longint unsigned cycle_count   = 0;

  signed_radix_formatter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor of the formatter
  // ---------------------------------------------------------------------------

  // digit index k to its alphabet character, low register holds digits 0 to 7
  function automatic logic [srf_pkg::CHAR_W-1:0] digit_char(
      input logic [srf_pkg::DIGIT_W-1:0] k);
    if (k < 8) begin
      return srf_pkg::CHAR_W'(alpha_lo_q >> (8 * k));
    end
    return srf_pkg::CHAR_W'(alpha_hi_q >> (8 * (k - 8)));
  endfunction

  // radix in 2..16, characters in use printable, no sign and no repeats
  function automatic bit alphabet_usable();
    logic [srf_pkg::CHAR_W-1:0] c;
    if (radix_q < 2 || radix_q > srf_pkg::MAX_RADIX_DEF) begin
      return 1'b0;
    end
    for (int a = 0; a < radix_q; a++) begin
      c = digit_char(srf_pkg::DIGIT_W'(a));
      if (c < 8'd32 || c > 8'd126 || c == srf_pkg::CHAR_PLUS || c == srf_pkg::CHAR_MINUS) begin
        return 1'b0;
      end
      for (int b = 0; b < a; b++) begin
        if (digit_char(srf_pkg::DIGIT_W'(b)) == c) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // queue the text of one number: sign, then digits most significant first
  task automatic predict_number(input logic [srf_pkg::NUM_W-1:0] raw);
    logic [srf_pkg::NUM_W-1:0]   mag;
    logic [srf_pkg::NUM_W-1:0]   base;
    logic [srf_pkg::DIGIT_W-1:0] digits [srf_pkg::DIGIT_SLOTS];
    int                          n;
    if (!alphabet_usable()) begin
      pending_chars.push_back(char_word_t'({srf_pkg::CHAR_NONE, 1'b1, 1'b1}));
      return;
    end
    // most negative value: 0 - raw wraps to 2^31 as an unsigned magnitude
    mag  = raw[srf_pkg::NUM_W-1] ? (32'd0 - raw) : raw;
    base = srf_pkg::NUM_W'(radix_q);
    n    = 0;
    do begin
      digits[n] = srf_pkg::DIGIT_W'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0 && n < srf_pkg::DIGIT_SLOTS);
    if (raw[srf_pkg::NUM_W-1]) begin
      pending_chars.push_back(char_word_t'({srf_pkg::CHAR_MINUS, 1'b0, 1'b0}));
    end
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back(char_word_t'({digit_char(digits[i]), i == 0, 1'b0}));
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers, all called on a rising edge and driving with nonblocking assignments
  // ---------------------------------------------------------------------------

  // one config write, the shadow follows what the block should keep
  task automatic write_reg(input logic [srf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srf_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      srf_pkg::REG_ALPHA_LOW:  alpha_lo_q = data;
      srf_pkg::REG_ALPHA_HIGH: alpha_hi_q = data;
      srf_pkg::REG_RADIX_SIZE: radix_q    = data[srf_pkg::RADIX_W-1:0];
      default: ;
    endcase
  endtask

  // full alphabet setup, upper radix bits random, plus a write to the unused index
  task automatic apply_alphabet(input logic [2*srf_pkg::ALPHA_W-1:0] alpha,
                                input logic [srf_pkg::RADIX_W-1:0] r);
    logic [srf_pkg::CFG_DATA_W-1:0] rdata;
    rdata = {$urandom, $urandom};
    rdata[srf_pkg::RADIX_W-1:0] = r;
    write_reg(srf_pkg::REG_ALPHA_LOW, alpha[srf_pkg::ALPHA_W-1:0]);
    write_reg(srf_pkg::REG_ALPHA_HIGH, alpha[2*srf_pkg::ALPHA_W-1:srf_pkg::ALPHA_W]);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(srf_pkg::REG_RADIX_SIZE, rdata);
    setups_done++;
    if (!alphabet_usable()) begin
      bad_setups++;
    end
  endtask

  // stop sending and let every expected word drain before touching the registers
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  // hand one number over; typed rows give the text, the rest go to the predictor
  task automatic send_number(input logic [srf_pkg::NUM_W-1:0] value, input bit typed,
                             input string text);
    int gap;
    if (sender_idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    numbers_sent++;
    if (!typed) begin
      predict_number(value);
    end else if (text.len() == 0) begin
      pending_chars.push_back(char_word_t'({srf_pkg::CHAR_NONE, 1'b1, 1'b1}));
    end else begin
      for (int k = 0; k < text.len(); k++) begin
        pending_chars.push_back(char_word_t'({text[k], k == text.len() - 1, 1'b0}));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  // mostly well-formed alphabets with random unused bytes, sometimes one defect
  task automatic random_alphabet(output logic [2*srf_pkg::ALPHA_W-1:0] a,
                                 output logic [srf_pkg::RADIX_W-1:0] r);
    bit taken [256];
    int c;
    int pos;
    int dup;
    r = srf_pkg::RADIX_W'($urandom_range(2, 16));
    for (int k = 0; k < 16; k++) begin
      a[k*8 +: 8] = 8'($urandom);
    end
    foreach (taken[i]) taken[i] = 1'b0;
    for (int k = 0; k < r; k++) begin
      do begin
        c = $urandom_range(32, 126);
      end while (c == srf_pkg::CHAR_PLUS || c == srf_pkg::CHAR_MINUS || taken[c]);
      taken[c] = 1'b1;
      a[k*8 +: 8] = 8'(c);
    end
    pos = $urandom_range(0, r - 1);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: r = $urandom_range(0, 1) ? srf_pkg::RADIX_W'($urandom_range(0, 1))
                                    : srf_pkg::RADIX_W'($urandom_range(17, 31));
        1: begin
          // control character or anything from delete upward
          c = $urandom_range(0, 160);
          a[pos*8 +: 8] = (c < 32) ? 8'(c) : 8'(c + 95);
        end
        2: a[pos*8 +: 8] = srf_pkg::CHAR_PLUS;
        3: a[pos*8 +: 8] = srf_pkg::CHAR_MINUS;
        default: begin
          dup = $urandom_range(0, r - 1);
          if (dup == pos) dup = (pos + 1) % r;
          a[dup*8 +: 8] = a[pos*8 +: 8];
        end
      endcase
    end
  endtask

  // full-range values, small values, sign extremes and powers of the radix
  function automatic logic [srf_pkg::NUM_W-1:0] pick_number(
      input logic [srf_pkg::RADIX_W-1:0] r);
    logic [63:0]               p;
    logic [63:0]               base;
    logic [srf_pkg::NUM_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = srf_pkg::NUM_W'($urandom_range(0, 600)) - 32'd300;
      3: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h0000_0001;
          3:       v = 32'h7FFF_FFFF;
          4:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      default: begin
        // digit count rolls over here, one off either side
        base = (r < 2 || r > 16) ? 64'd2 : 64'(r);
        p    = 64'd1;
        repeat ($urandom_range(0, 31)) begin
          if (p * base <= 64'h8000_0000) p = p * base;
        end
        v = p[srf_pkg::NUM_W-1:0] + srf_pkg::NUM_W'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall bursts, and the word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_hold = $urandom_range(1, 13);
    end
    out_stall_i <= (stall_hold > 0);
  end

  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (pending_chars.size() == 0) begin
        $display("%0t: word with none expected, expected nothing actual char %h last %b err %b",
                 $time, character_o, last_o, error_o);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) begin
          $display("%0t: character mismatch, expected %h actual %h", $time, want.ch, character_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last_o);
          mismatches++;
        end
        if (error_o !== want.err) begin
          $display("%0t: error mismatch, expected %b actual %b", $time, want.err, error_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, pending_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  task automatic add_setup(input logic [2*srf_pkg::ALPHA_W-1:0] alpha,
                           input logic [srf_pkg::RADIX_W-1:0] r);
    dir_rows.push_back('{kind: ROW_SETUP, alpha: alpha, radix: r, num: '0, text: ""});
  endtask

  task automatic add_typed(input logic [srf_pkg::NUM_W-1:0] num, input string text);
    dir_rows.push_back('{kind: ROW_TYPED, alpha: '0, radix: '0, num: num, text: text});
  endtask

  task automatic add_model(input logic [srf_pkg::NUM_W-1:0] num);
    dir_rows.push_back('{kind: ROW_MODEL, alpha: '0, radix: '0, num: num, text: ""});
  endtask

  // string literals pack with the last character in byte 0, so digit k sits in byte k
  // when the alphabet is written backwards
  task automatic build_table();
    // straight out of reset the radix is zero, so the alphabet is unusable
    add_typed(32'd1234, "");
    add_setup("9876543210", 5'd10);
    add_typed(32'd0, "0");
    add_typed(32'h7FFF_FFFF, "2147483647");
    add_typed(32'h8000_0000, "-2147483648");
    add_typed(-32'sd1, "-1");
    add_model(-32'sd987654321);
    // binary: most negative value gives the longest text, sign plus 32 digits
    add_setup("10", 5'd2);
    add_model(32'h8000_0000);
    add_model(32'h7FFF_FFFF);
    add_typed(-32'sd1, "-1");
    add_setup("FEDCBA9876543210", 5'd16);
    add_typed(32'h8000_0000, "-80000000");
    add_typed(32'h12AB_CDEF, "12ABCDEF");
    add_typed(-32'sd1, "-1");
    // lowest and highest printable characters as digits
    add_setup("~ ", 5'd2);
    add_model(32'd5);
    // each way an alphabet can be rejected
    add_setup("10", 5'd1);
    add_typed(32'd7, "");
    add_setup("FEDCBA9876543210", 5'd17);
    add_typed(32'd7, "");
    add_setup("FEDCBA9876543210", 5'd31);
    add_typed(-32'sd7, "");
    add_setup({8'h7F, "0"}, 5'd2);
    add_typed(32'd3, "");
    add_setup({"0", 8'h1F}, 5'd2);
    add_typed(32'd3, "");
    add_setup("+0", 5'd2);
    add_typed(32'd3, "");
    add_setup("0-", 5'd2);
    add_typed(32'd3, "");
    // first and last digit the same
    add_setup("0EDCBA9876543210", 5'd16);
    add_typed(32'd3, "");
    // bytes past the radix hold a repeat, both signs and a high byte, all ignored
    add_setup({8'hFF, "+-0", "210"}, 5'd3);
    add_typed(-32'sd5, "-12");
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [2*srf_pkg::ALPHA_W-1:0] alpha;
    logic [srf_pkg::RADIX_W-1:0]   r;
    build_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_SETUP: begin
          drain_block();
          apply_alphabet(dir_rows[i].alpha, dir_rows[i].radix);
        end
        ROW_TYPED: send_number(dir_rows[i].num, 1'b1, dir_rows[i].text);
        default:   send_number(dir_rows[i].num, 1'b0, "");
      endcase
    end

    // random alphabets; each phase waits for the block to empty before reconfiguring,
    // the last phase runs with no idling on either side, set before the drain so
    // that no stall burst is left over
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) begin
        sender_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
      end else begin
        sender_idle_en = ($urandom_range(0, 3) != 0);
        sink_idle_en   = ($urandom_range(0, 3) != 0);
      end
      drain_block();
      random_alphabet(alpha, r);
      apply_alphabet(alpha, r);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_number(pick_number(r), 1'b0, "");
      end
    end

    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (64) @(posedge clk_i);

    $display("formatted %0d numbers under %0d alphabet settings (%0d of them rejected)",
             numbers_sent, setups_done, bad_setups);
    $display("checked %0d output characters, radix 2 to 16 and both sign extremes",
             words_checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
